// ----- hw/rtl/mlfq_pkg.sv -----
// Shared constants, types and codes for the feedback queue scheduler.
package mlfq_pkg;

    localparam int MAX_THREADS = 8;
    localparam int NUM_LEVELS  = 3;
    localparam int ID_W        = $clog2(MAX_THREADS);
    localparam int CNT_W       = $clog2(MAX_THREADS + 1);
    localparam int LVL_W       = 2;

    typedef logic [ID_W-1:0]  id_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [LVL_W-1:0] lvl_t;

    // configuration register indexes
    localparam logic [1:0] REG_BOOST_PERIOD = 2'd0;
    localparam logic [1:0] REG_SLICE_LEVEL0 = 2'd1;
    localparam logic [1:0] REG_SLICE_LEVEL1 = 2'd2;
    localparam logic [1:0] REG_SLICE_LEVEL2 = 2'd3;

    // command codes
    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // per-queue control
    typedef struct packed {
        logic push;
        logic pop;
        id_t  push_id;
    } q_ctrl_t;

endpackage

// ----- hw/rtl/mlfq_scheduler_unit.sv -----
// Top level of the three-level feedback queue scheduler.
//
// Each level is a FIFO built as a row of cells that shift one slot toward the
// head on every pop; a small sequencer moves thread ids between levels. An add
// transaction gives no result. A tick transaction goes straight to the result
// state when the running thread keeps its slice; otherwise it passes through
// the demote and pick states, or, when a priority boost happens, through the
// boost and pick states, where the boost moves one id per cycle from levels 1
// and 2 through the level-0 tail. Results leave through an output
// register; a tick waits in its last state while that register is still full.
module mlfq_scheduler_unit import mlfq_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] need
    input  logic        s_tuser,   // [0] cmd
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] running, [3:1] thread_id, [5:4] level, [21:6] remaining,
    // [22] boosted, [23] zero
    output logic [23:0] m_tdata,
    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_BOOST, ST_DEMOTE, ST_PICK, ST_OUT
    } state_t;

    state_t      state_reg;
    logic [15:0] boost_period_reg;
    logic [7:0]  slice_cfg_reg [NUM_LEVELS];

    logic [15:0] need_tbl  [MAX_THREADS];
    logic [15:0] run_tbl   [MAX_THREADS];
    logic [7:0]  slice_tbl [MAX_THREADS];
    lvl_t        lvl_tbl   [MAX_THREADS];

    logic        cur_valid_reg;
    id_t         cur_id_reg;
    logic [15:0] tick_reg;
    cnt_t        added_reg;
    logic        boosted_reg;
    logic        m_tvalid_reg;
    logic [23:0] m_tdata_reg;

    q_ctrl_t q_ctl  [NUM_LEVELS];
    id_t     q_head [NUM_LEVELS];
    cnt_t    q_cnt  [NUM_LEVELS];

    genvar g;
    generate
        for (g = 0; g < NUM_LEVELS; g++) begin : g_q
            mlfq_queue u_queue (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctrl    (q_ctl[g]),
                .head    (q_head[g]),
                .count   (q_cnt[g])
            );
        end
    endgenerate

    // current thread view
    logic [15:0] cur_need, cur_run;
    logic [7:0]  cur_slice, cur_lim;
    lvl_t        cur_lvl, demote_lvl;
    logic        cur_unf, stay, s_fire, out_free;
    logic [16:0] run_p1;
    logic [15:0] rem;

    assign cur_need  = need_tbl[cur_id_reg];
    assign cur_run   = run_tbl[cur_id_reg];
    assign cur_slice = slice_tbl[cur_id_reg];
    assign cur_lvl   = lvl_tbl[cur_id_reg];
    assign cur_unf   = cur_run < cur_need;
    assign run_p1    = {1'b0, cur_run} + 17'd1;
    // remaining = need - run - 1 when positive
    assign rem       = ({1'b0, cur_need} > run_p1) ? 16'({1'b0, cur_need} - run_p1) : 16'd0;

    always_comb begin
        case (cur_lvl)
            2'd0:    cur_lim = slice_cfg_reg[0];
            2'd1:    cur_lim = slice_cfg_reg[1];
            2'd2:    cur_lim = slice_cfg_reg[2];
            default: cur_lim = 8'd0;
        endcase
    end

    assign demote_lvl = (cur_lvl >= lvl_t'(NUM_LEVELS - 1)) ? lvl_t'(NUM_LEVELS - 1)
                                                             : cur_lvl + lvl_t'(1);
    assign stay     = cur_valid_reg && (cur_slice < cur_lim) && cur_unf;
    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // queue controls from the sequencer
    always_comb begin
        for (int l = 0; l < NUM_LEVELS; l++) begin
            q_ctl[l] = '0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_fire && s_tuser == CMD_ADD && added_reg < cnt_t'(MAX_THREADS)) begin
                    q_ctl[0].push    = 1'b1;
                    q_ctl[0].push_id = id_t'(added_reg);
                end
            end
            ST_BOOST: begin
                if (q_cnt[1] != '0) begin
                    q_ctl[1].pop     = 1'b1;
                    q_ctl[0].push    = 1'b1;
                    q_ctl[0].push_id = q_head[1];
                end else if (q_cnt[2] != '0) begin
                    q_ctl[2].pop     = 1'b1;
                    q_ctl[0].push    = 1'b1;
                    q_ctl[0].push_id = q_head[2];
                end else if (cur_valid_reg && cur_unf) begin
                    q_ctl[0].push    = 1'b1;
                    q_ctl[0].push_id = cur_id_reg;
                end
            end
            ST_DEMOTE: begin
                if (cur_valid_reg && cur_unf) begin
                    q_ctl[demote_lvl].push    = 1'b1;
                    q_ctl[demote_lvl].push_id = cur_id_reg;
                end
            end
            ST_PICK: begin
                if (q_cnt[0] != '0) begin
                    q_ctl[0].pop = 1'b1;
                end else if (q_cnt[1] != '0) begin
                    q_ctl[1].pop = 1'b1;
                end else if (q_cnt[2] != '0) begin
                    q_ctl[2].pop = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // thread tables (no reset: entries are written before being read)
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_fire && s_tuser == CMD_ADD && added_reg < cnt_t'(MAX_THREADS)) begin
                    need_tbl[id_t'(added_reg)]  <= s_tdata;
                    run_tbl[id_t'(added_reg)]   <= '0;
                    slice_tbl[id_t'(added_reg)] <= '0;
                    lvl_tbl[id_t'(added_reg)]   <= '0;
                end
            end
            ST_BOOST: begin
                if (q_cnt[1] != '0) begin
                    lvl_tbl[q_head[1]] <= '0;
                end else if (q_cnt[2] != '0) begin
                    lvl_tbl[q_head[2]] <= '0;
                end else if (cur_valid_reg && cur_unf) begin
                    lvl_tbl[cur_id_reg] <= '0;
                end
            end
            ST_DEMOTE: begin
                if (cur_valid_reg && cur_unf) begin
                    lvl_tbl[cur_id_reg]   <= demote_lvl;
                    slice_tbl[cur_id_reg] <= '0;
                end
            end
            ST_OUT: begin
                if (out_free && cur_valid_reg) begin
                    if (cur_slice != 8'hFF) begin
                        slice_tbl[cur_id_reg] <= cur_slice + 8'd1;
                    end
                    if (cur_run != 16'hFFFF) begin
                        run_tbl[cur_id_reg] <= cur_run + 16'd1;
                    end
                end
            end
            default: ;
        endcase
    end

    // sequencer, configuration and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            boost_period_reg <= 16'd25;
            slice_cfg_reg[0] <= 8'd1;
            slice_cfg_reg[1] <= 8'd2;
            slice_cfg_reg[2] <= 8'd3;
            cur_valid_reg    <= 1'b0;
            cur_id_reg       <= '0;
            tick_reg         <= '0;
            added_reg        <= '0;
            boosted_reg      <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_BOOST_PERIOD: boost_period_reg <= cfg_wdata;
                    REG_SLICE_LEVEL0: slice_cfg_reg[0] <= cfg_wdata[7:0];
                    REG_SLICE_LEVEL1: slice_cfg_reg[1] <= cfg_wdata[7:0];
                    REG_SLICE_LEVEL2: slice_cfg_reg[2] <= cfg_wdata[7:0];
                    default: ;
                endcase
            end
            // a new result in the same cycle refills the register below
            if (m_tvalid_reg && m_tready && !(state_reg == ST_OUT && out_free)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        if (s_tuser == CMD_ADD) begin
                            if (added_reg < cnt_t'(MAX_THREADS)) begin
                                added_reg <= added_reg + cnt_t'(1);
                            end
                        end else if (stay) begin
                            boosted_reg <= 1'b0;
                            state_reg   <= ST_OUT;
                        end else if (tick_reg >= boost_period_reg) begin
                            tick_reg    <= '0;
                            boosted_reg <= 1'b1;
                            state_reg   <= ST_BOOST;
                        end else begin
                            boosted_reg <= 1'b0;
                            state_reg   <= ST_DEMOTE;
                        end
                    end
                end
                ST_BOOST: begin
                    if (q_cnt[1] == '0 && q_cnt[2] == '0) begin
                        cur_valid_reg <= 1'b0;
                        state_reg     <= ST_PICK;
                    end
                end
                ST_DEMOTE: begin
                    cur_valid_reg <= 1'b0;
                    state_reg     <= ST_PICK;
                end
                ST_PICK: begin
                    if (q_cnt[0] != '0) begin
                        cur_id_reg    <= q_head[0];
                        cur_valid_reg <= 1'b1;
                    end else if (q_cnt[1] != '0) begin
                        cur_id_reg    <= q_head[1];
                        cur_valid_reg <= 1'b1;
                    end else if (q_cnt[2] != '0) begin
                        cur_id_reg    <= q_head[2];
                        cur_valid_reg <= 1'b1;
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        if (cur_valid_reg) begin
                            m_tdata_reg <= {1'b0, boosted_reg, rem,
                                            cur_lvl, cur_id_reg, 1'b1};
                            if (tick_reg != 16'hFFFF) begin
                                tick_reg <= tick_reg + 16'd1;
                            end
                        end else begin
                            // idle tick: nothing runs, tick count holds
                            m_tdata_reg <= {1'b0, boosted_reg, 22'd0};
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---- assertions ----
    logic [CNT_W+1:0] queued_total;
    assign queued_total = (CNT_W+2)'(q_cnt[0]) + (CNT_W+2)'(q_cnt[1])
                        + (CNT_W+2)'(q_cnt[2]);

    a_no_extra_threads: assert property (@(posedge aclk) disable iff (!aresetn)
        queued_total <= (CNT_W+2)'(added_reg))
        else $error("more threads queued than were added");

    a_idle_result_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[21:1] == 21'd0))
        else $error("idle tick result carries thread fields");

    a_pick_then_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PICK) |=> (state_reg == ST_OUT))
        else $error("pick did not lead to result");

endmodule

// ----- hw/rtl/mlfq_cell.sv -----
// One queue slot: holds a thread id, shifts toward the head or loads a push.
module mlfq_cell import mlfq_pkg::*; (
    input  logic aclk,
    input  logic shift,
    input  id_t  next_id,
    input  logic load,
    input  id_t  load_id,
    output id_t  id
);

    id_t id_reg;

    always_ff @(posedge aclk) begin
        if (load) begin
            id_reg <= load_id;
        end else if (shift) begin
            id_reg <= next_id;
        end
    end

    assign id = id_reg;

endmodule

// ----- hw/rtl/mlfq_queue.sv -----
// FIFO of thread ids built from a row of shifting cells plus a fill count.
module mlfq_queue import mlfq_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  q_ctrl_t ctrl,
    output id_t     head,
    output cnt_t    count
);

    cnt_t count_reg;
    id_t  cell_id [MAX_THREADS];

    genvar i;
    generate
        for (i = 0; i < MAX_THREADS; i++) begin : g_cell
            id_t  nxt;
            logic ld;
            if (i < MAX_THREADS - 1) begin : g_mid
                assign nxt = cell_id[i+1];
            end else begin : g_last
                assign nxt = '0;
            end
            // push lands at the tail slot; pop and push never share a cycle
            assign ld = ctrl.push && (count_reg == cnt_t'(i));
            mlfq_cell u_cell (
                .aclk    (aclk),
                .shift   (ctrl.pop),
                .next_id (nxt),
                .load    (ld),
                .load_id (ctrl.push_id),
                .id      (cell_id[i])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (ctrl.push && count_reg < cnt_t'(MAX_THREADS)) begin
            count_reg <= count_reg + cnt_t'(1);
        end else if (ctrl.pop && count_reg != '0) begin
            count_reg <= count_reg - cnt_t'(1);
        end
    end

    assign head  = cell_id[0];
    assign count = count_reg;

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the three-level feedback queue scheduler.
module tb_top;
    import mlfq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // result layout, high bit down to low bit
    typedef struct packed {
        logic        pad;
        logic        boosted;
        logic [15:0] remaining;
        lvl_t        level;
        id_t         tid;
        logic        running;
    } sched_res_t;

    // Scoreboard: tracks the scheduler state and holds the expected results
    class sched_scoreboard;
        logic [15:0] boost_period;
        logic [7:0]  slice_cfg [NUM_LEVELS];
        logic [15:0] need_tab  [MAX_THREADS];
        logic [15:0] run_tab   [MAX_THREADS];
        logic [7:0]  slc_tab   [MAX_THREADS];
        lvl_t        lvl_tab   [MAX_THREADS];
        id_t         lvl_q     [NUM_LEVELS][$];
        logic        cur_valid;
        id_t         cur_id;
        logic [15:0] tick_cnt;
        int          added;
        sched_res_t  exp_q [$];
        int          errors;

        function new();
            boost_period = 16'd25;
            slice_cfg[0] = 8'd1;
            slice_cfg[1] = 8'd2;
            slice_cfg[2] = 8'd3;
            cur_valid = 1'b0;
            cur_id = '0;
            tick_cnt = '0;
            added = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                REG_BOOST_PERIOD: boost_period = val;
                REG_SLICE_LEVEL0: slice_cfg[0] = val[7:0];
                REG_SLICE_LEVEL1: slice_cfg[1] = val[7:0];
                REG_SLICE_LEVEL2: slice_cfg[2] = val[7:0];
                default: ;
            endcase
        endfunction

        function void enqueue(int lvl, id_t id);
            if (lvl_q[lvl].size() < MAX_THREADS) begin
                lvl_q[lvl].push_back(id);
                lvl_tab[id] = lvl_t'(lvl);
            end
        endfunction

        function logic unfinished(id_t id);
            return run_tab[id] < need_tab[id];
        endfunction

        // preempt / boost / pick the next thread; returns the boost flag
        function logic reschedule();
            logic boosted;
            int dst;
            boosted = 1'b0;
            if (tick_cnt >= boost_period) begin
                tick_cnt = '0;
                boosted = 1'b1;
                for (int l = 1; l < NUM_LEVELS; l++)
                    while (lvl_q[l].size() > 0) enqueue(0, lvl_q[l].pop_front());
                if (cur_valid && unfinished(cur_id)) enqueue(0, cur_id);
                cur_valid = 1'b0;
            end
            if (cur_valid && unfinished(cur_id)) begin
                dst = int'(lvl_tab[cur_id]) + 1;
                if (dst > NUM_LEVELS - 1) dst = NUM_LEVELS - 1;
                slc_tab[cur_id] = '0;
                enqueue(dst, cur_id);
            end
            cur_valid = 1'b0;
            for (int l = 0; l < NUM_LEVELS; l++) begin
                if (lvl_q[l].size() > 0) begin
                    cur_id = lvl_q[l].pop_front();
                    cur_valid = 1'b1;
                    break;
                end
            end
            return boosted;
        endfunction

        function void note_input(logic cmd, logic [15:0] need);
            sched_res_t r;
            logic b;
            if (cmd == CMD_ADD) begin
                if (added < MAX_THREADS) begin
                    need_tab[added] = need;
                    run_tab[added] = '0;
                    slc_tab[added] = '0;
                    enqueue(0, id_t'(added));
                    added++;
                end
                return;
            end
            b = 1'b0;
            if (!cur_valid)
                b = reschedule();
            else if (!(slc_tab[cur_id] < slice_cfg[lvl_tab[cur_id]] && unfinished(cur_id)))
                b = reschedule();
            r = '0;
            r.boosted = b;
            if (cur_valid) begin
                r.running = 1'b1;
                r.tid = cur_id;
                r.level = lvl_tab[cur_id];
                r.remaining = (32'(need_tab[cur_id]) > 32'(run_tab[cur_id]) + 1) ?
                              need_tab[cur_id] - run_tab[cur_id] - 16'd1 : 16'd0;
                if (slc_tab[cur_id] != 8'hFF) slc_tab[cur_id]++;
                if (run_tab[cur_id] != 16'hFFFF) run_tab[cur_id]++;
                if (tick_cnt != 16'hFFFF) tick_cnt++;
            end
            exp_q.push_back(r);
        endfunction

        function void check_result(sched_res_t got);
            sched_res_t w;
            if (exp_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            w = exp_q.pop_front();
            if (got.running !== w.running) begin
                $display("%0t: running exp %0d got %0d", $time, w.running, got.running);
                errors++;
            end
            if (got.tid !== w.tid) begin
                $display("%0t: thread_id exp %0d got %0d", $time, w.tid, got.tid);
                errors++;
            end
            if (got.level !== w.level) begin
                $display("%0t: level exp %0d got %0d", $time, w.level, got.level);
                errors++;
            end
            if (got.remaining !== w.remaining) begin
                $display("%0t: remaining exp %0d got %0d", $time, w.remaining, got.remaining);
                errors++;
            end
            if (got.boosted !== w.boosted) begin
                $display("%0t: boosted exp %0d got %0d", $time, w.boosted, got.boosted);
                errors++;
            end
            if (got.pad !== 1'b0) begin
                $display("%0t: pad bit exp 0 got %b", $time, got.pad);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;   // [15:0] need
    logic        s_tuser = 1'b0; // [0] cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;        // running, thread_id, level, remaining, boosted, zero
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [15:0] cfg_wdata = '0;

    sched_scoreboard sb = new();
    bit calm = 1'b0;   // when set, neither side idles

    always #5 aclk = ~aclk;

    mlfq_scheduler_unit DUT (.*);

    // Result side: random back-pressure, check on every transaction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(sched_res_t'(m_tdata));
        m_tready <= calm || ($urandom_range(0, 99) >= 19);
    end

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    // Drive one input transaction; the model is updated at acceptance.
    task automatic send_item(logic cmd, logic [15:0] need);
        if (!calm && $urandom_range(0, 99) < 19) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= need;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(cmd, need);
    endtask

    // Let the block drain before touching the registers.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.exp_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic random_item();
        logic [15:0] need;
        if ($urandom_range(0, 99) < 8) begin
            // mostly short jobs, occasionally a very long one
            need = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 65535))
                                              : 16'($urandom_range(1, 120));
            send_item(CMD_ADD, need);
        end else begin
            send_item(CMD_TICK, 16'($urandom));
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: an idle tick, zero need, full-scale need, zero slices and
        // zero boost period, then one-tick slices.
        write_reg(REG_BOOST_PERIOD, 16'd0);
        write_reg(REG_SLICE_LEVEL0, 16'd0);
        write_reg(REG_SLICE_LEVEL1, 16'd0);
        write_reg(REG_SLICE_LEVEL2, 16'd0);
        send_item(CMD_TICK, 16'h0000);
        send_item(CMD_ADD, 16'h0000);
        send_item(CMD_ADD, 16'hFFFF);
        send_item(CMD_ADD, 16'd3);
        repeat (6) send_item(CMD_TICK, 16'hFFFF);
        drain();
        write_reg(REG_BOOST_PERIOD, 16'd1);
        write_reg(REG_SLICE_LEVEL0, 16'd1);
        write_reg(REG_SLICE_LEVEL1, 16'd1);
        write_reg(REG_SLICE_LEVEL2, 16'd1);
        send_item(CMD_ADD, 16'd1);
        repeat (8) send_item(CMD_TICK, 16'h0000);
        drain();

        // Random phases under different settings, largest values included.
        write_reg(REG_BOOST_PERIOD, 16'hFFFF);
        write_reg(REG_SLICE_LEVEL0, 16'd255);
        write_reg(REG_SLICE_LEVEL1, 16'd255);
        write_reg(REG_SLICE_LEVEL2, 16'd255);
        repeat (150) random_item();
        drain();
        write_reg(REG_BOOST_PERIOD, 16'd25);
        write_reg(REG_SLICE_LEVEL0, 16'd1);
        write_reg(REG_SLICE_LEVEL1, 16'd2);
        write_reg(REG_SLICE_LEVEL2, 16'd3);
        calm = 1'b1;   // back-to-back stretch
        repeat (200) random_item();
        calm = 1'b0;
        drain();
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(REG_BOOST_PERIOD, 16'($urandom_range(0, 40)));
            write_reg(REG_SLICE_LEVEL0, 16'($urandom_range(0, 4)));
            write_reg(REG_SLICE_LEVEL1, 16'($urandom_range(0, 6)));
            write_reg(REG_SLICE_LEVEL2, 16'($urandom_range(0, 8)));
            repeat (150) random_item();
            drain();
        end

        if (sb.errors == 0 && sb.exp_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- mlfq_scheduler_unit.f -----
hw/rtl/mlfq_pkg.sv
hw/rtl/mlfq_cell.sv
hw/rtl/mlfq_queue.sv
hw/rtl/mlfq_scheduler_unit.sv
sim/tb_top.sv
